FILE: sv/aptp_pkg.sv
// Shared types and constants of the aging priority task picker.
`timescale 1ns / 1ps
`default_nettype none

package aptp_pkg;

  localparam int unsigned MaxTasksDef = 16;
  localparam int unsigned IdW         = 8;
  localparam int unsigned PrioW       = 6;
  localparam int unsigned AgeW        = 8;
  localparam int unsigned LimitW      = 7;
  localparam int unsigned EffW        = 10;

  localparam logic [LimitW-1:0] LimitReset = 7'd20;
  localparam logic [AgeW-1:0]   AgeMax     = 8'hFF;

  typedef enum logic [1:0] {
    CMD_ADD      = 2'd0,
    CMD_REMOVE   = 2'd1,
    CMD_SET_PRIO = 2'd2,
    CMD_PICK     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_NONE      = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD,
    S_FIND,
    S_SHINIT,
    S_SHIFT,
    S_PICK,
    S_PSEL,
    S_TAIL,
    S_RESULT
  } state_e;

  typedef struct packed {
    logic [IdW-1:0]          id;
    logic signed [PrioW-1:0] prio;
    logic [AgeW-1:0]         age;
  } entry_t;

  typedef struct packed {
    logic    capture;
    logic    add;
    logic    find;
    logic    set_wr;
    logic    shinit;
    logic    shift;
    logic    pick;
    logic    tail;
    logic    dec_len;
    logic    set_st;
    status_e st;
    logic    load_out;
  } ctl_t;

  typedef struct packed {
    cmd_e op;
    logic full;
    logic match;
    logic scan_done;
    logic found;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

FILE: sv/aptp_ctrl.sv
// Controller state machine of the aging priority task picker.
`timescale 1ns / 1ps
`default_nettype none

module aptp_ctrl import aptp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output ctl_t ctl_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (sts_i.op)
            CMD_ADD:                 state_d = S_ADD;
            CMD_REMOVE, CMD_SET_PRIO: state_d = S_FIND;
            CMD_PICK:                state_d = S_PICK;
            default:                 state_d = S_ADD;
          endcase
        end
      end
      S_ADD: state_d = S_RESULT;
      S_FIND: begin
        if (sts_i.match) begin
          state_d = (sts_i.op == CMD_SET_PRIO) ? S_RESULT : S_SHINIT;
        end else if (sts_i.scan_done) begin
          state_d = S_RESULT;
        end
      end
      S_SHINIT: state_d = S_SHIFT;
      S_SHIFT: begin
        if (sts_i.scan_done) begin
          state_d = (sts_i.op == CMD_REMOVE) ? S_RESULT : S_TAIL;
        end
      end
      S_PICK: begin
        if (sts_i.scan_done) state_d = S_PSEL;
      end
      S_PSEL:   state_d = sts_i.found ? S_SHINIT : S_RESULT;
      S_TAIL:   state_d = S_RESULT;
      S_RESULT: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctl_o      = '0;
    ctl_o.st   = ST_OK;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        ctl_o.capture = in_valid_i;
      end
      S_ADD: begin
        ctl_o.add    = !sts_i.full;
        ctl_o.set_st = 1'b1;
        ctl_o.st     = sts_i.full ? ST_FULL : ST_OK;
      end
      S_FIND: begin
        ctl_o.find = 1'b1;
        if (sts_i.match) begin
          ctl_o.set_wr = (sts_i.op == CMD_SET_PRIO);
          ctl_o.set_st = 1'b1;
          ctl_o.st     = ST_OK;
        end else if (sts_i.scan_done) begin
          ctl_o.set_st = 1'b1;
          ctl_o.st     = ST_NOT_FOUND;
        end
      end
      S_SHINIT: ctl_o.shinit = 1'b1;
      S_SHIFT: begin
        ctl_o.shift = 1'b1;
        if (sts_i.scan_done && sts_i.op == CMD_REMOVE) begin
          ctl_o.dec_len = 1'b1;
          ctl_o.set_st  = 1'b1;
          ctl_o.st      = ST_OK;
        end
      end
      S_PICK: ctl_o.pick = 1'b1;
      S_PSEL: begin
        if (!sts_i.found) begin
          ctl_o.set_st = 1'b1;
          ctl_o.st     = ST_NONE;
        end
      end
      S_TAIL: begin
        ctl_o.tail   = 1'b1;
        ctl_o.set_st = 1'b1;
        ctl_o.st     = ST_OK;
      end
      S_RESULT: ctl_o.load_out = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/aptp_dpath.sv
// Datapath of the aging priority task picker: entry memory, scan and output register.
`timescale 1ns / 1ps
`default_nettype none

module aptp_dpath import aptp_pkg::*; #(
  parameter int unsigned MAX_TASKS = MaxTasksDef,
  parameter int unsigned AW        = $clog2(MAX_TASKS),
  parameter int unsigned LW        = $clog2(MAX_TASKS + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [LimitW-1:0]        cfg_wdata_i,
  input  logic [1:0]               cmd_i,
  input  logic [IdW-1:0]           task_id_i,
  input  logic signed [PrioW-1:0]  priority_req_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [1:0]               status_o,
  output logic [IdW-1:0]           chosen_id_o,
  output logic [LW-1:0]            ready_count_o,
  input  ctl_t                     ctl_i,
  output sts_t                     sts_o
);

  entry_t mem [MAX_TASKS];

  logic [LimitW-1:0]       limit_q;
  logic [LW-1:0]           len_q;
  cmd_e                    op_q;
  logic [IdW-1:0]          id_q;
  logic signed [PrioW-1:0] prio_q;
  logic [LW-1:0]           rp_q, pp_q, win_q;
  logic                    rv_q, found_q;
  entry_t                  rdata_q;
  logic signed [EffW-1:0]  best_q;
  logic [IdW-1:0]          wid_q;
  logic signed [PrioW-1:0] wpr_q;
  status_e                 res_st_q;
  logic [IdW-1:0]          res_id_q;
  logic                    out_valid_q;
  logic [1:0]              out_st_q;
  logic [IdW-1:0]          out_id_q;
  logic [LW-1:0]           out_cnt_q;

  logic                    scanning, issue, match, better;
  logic signed [EffW-1:0]  eff;
  logic [LW-1:0]           pp_m1, len_m1;
  logic                    we;
  logic [AW-1:0]           waddr;
  entry_t                  wdata;
  logic [AgeW-1:0]         age_inc;

  assign scanning = ctl_i.find | ctl_i.shift | ctl_i.pick;
  assign issue    = scanning && (rp_q < len_q);
  assign match    = rv_q && (rdata_q.id == id_q);
  assign eff      = {{(EffW - PrioW){rdata_q.prio[PrioW-1]}}, rdata_q.prio}
                  - {{(EffW - AgeW){1'b0}}, rdata_q.age};
  assign better   = ctl_i.pick && rv_q && (eff < best_q);
  assign pp_m1    = pp_q - LW'(1);
  assign len_m1   = len_q - LW'(1);
  assign age_inc  = (rdata_q.age == AgeMax) ? rdata_q.age : rdata_q.age + AgeW'(1);

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = rdata_q;
    priority if (ctl_i.add) begin
      we    = 1'b1;
      waddr = len_q[AW-1:0];
      wdata = '{id: id_q, prio: prio_q, age: '0};
    end else if (ctl_i.set_wr) begin
      we    = 1'b1;
      waddr = pp_q[AW-1:0];
      wdata = '{id: rdata_q.id, prio: prio_q, age: rdata_q.age};
    end else if (ctl_i.shift && rv_q) begin
      we    = 1'b1;
      waddr = pp_m1[AW-1:0];
      wdata = rdata_q;
    end else if (ctl_i.pick && rv_q) begin
      we    = 1'b1;
      waddr = pp_q[AW-1:0];
      wdata = '{id: rdata_q.id, prio: rdata_q.prio, age: age_inc};
    end else if (ctl_i.tail) begin
      we    = 1'b1;
      waddr = len_m1[AW-1:0];
      wdata = '{id: wid_q, prio: wpr_q, age: '0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (issue) rdata_q <= mem[rp_q[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= LimitReset;
      len_q       <= '0;
      rp_q        <= '0;
      pp_q        <= '0;
      rv_q        <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      if (ctl_i.add) begin
        len_q <= len_q + LW'(1);
      end else if (ctl_i.dec_len) begin
        len_q <= len_m1;
      end
      if (ctl_i.capture) begin
        rp_q <= '0;
      end else if (ctl_i.shinit) begin
        rp_q <= win_q + LW'(1);
      end else if (issue) begin
        rp_q <= rp_q + LW'(1);
      end
      if (issue) pp_q <= rp_q;
      rv_q <= issue;
      if (ctl_i.capture) begin
        found_q <= 1'b0;
      end else if (better) begin
        found_q <= 1'b1;
      end
      if (ctl_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      op_q     <= cmd_e'(cmd_i);
      id_q     <= task_id_i;
      prio_q   <= priority_req_i;
      best_q   <= {{(EffW - LimitW){limit_q[LimitW-1]}}, limit_q};
      res_id_q <= '0;
    end
    if (ctl_i.find && match) win_q <= pp_q;
    if (better) begin
      best_q <= eff;
      win_q  <= pp_q;
      wid_q  <= rdata_q.id;
      wpr_q  <= rdata_q.prio;
    end
    if (ctl_i.tail) res_id_q <= wid_q;
    if (ctl_i.set_st) res_st_q <= ctl_i.st;
    if (ctl_i.load_out) begin
      out_st_q  <= res_st_q;
      out_id_q  <= res_id_q;
      out_cnt_q <= len_q;
    end
  end

  assign sts_o.op        = ctl_i.capture ? cmd_e'(cmd_i) : op_q;
  assign sts_o.full      = (len_q == LW'(MAX_TASKS));
  assign sts_o.match     = match;
  assign sts_o.scan_done = (rp_q >= len_q);
  assign sts_o.found     = found_q;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_st_q;
  assign chosen_id_o   = out_id_q;
  assign ready_count_o = out_cnt_q;

endmodule

`default_nettype wire

FILE: sv/aging_priority_task_picker_core.sv
// Top level of the aging priority task picker.
// Usage: a request (cmd_i, task_id_i, priority_req_i) enters on in_valid_i/in_ready_o;
// one result (status_o, chosen_id_o, ready_count_o) leaves on out_valid_o/out_ready_i
// for every request. cfg_we_i writes select_limit from cfg_wdata_i; the user must
// do so only while idle, which the block does not enforce. One request is worked on
// at a time; in_ready_o is high only in the idle state.
// Work per request, with N entries in the list:
//   add: a direct write; set priority or remove of an unknown id: a scan of the list;
//   remove: a scan, then compaction behind the removed entry;
//   pick: a scan, then with a winner compaction behind it and a move to the tail.
// The entry memory has one read and one write port; scan and compaction move one
// entry per cycle.
// The next request can be accepted in the cycle after the result is loaded.
// The result waits in an output register; a new request is accepted while it
// waits, and the block holds its next result until out_ready_i frees the register.
// Reset empties the list, sets select_limit to 20 and drops any pending result;
// the entry memory is not cleared, only entries below the list length are read.
`timescale 1ns / 1ps
`default_nettype none

module aging_priority_task_picker_core import aptp_pkg::*; #(
  parameter int unsigned MAX_TASKS = MaxTasksDef,
  parameter int unsigned LW        = $clog2(MAX_TASKS + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [LimitW-1:0]       cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              cmd_i,
  input  logic [IdW-1:0]          task_id_i,
  input  logic signed [PrioW-1:0] priority_req_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [1:0]              status_o,
  output logic [IdW-1:0]          chosen_id_o,
  output logic [LW-1:0]           ready_count_o
);

  ctl_t ctl;
  sts_t sts;

  aptp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  aptp_dpath #(
    .MAX_TASKS (MAX_TASKS),
    .AW        ($clog2(MAX_TASKS)),
    .LW        (LW)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .cmd_i          (cmd_i),
    .task_id_i      (task_id_i),
    .priority_req_i (priority_req_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .chosen_id_o    (chosen_id_o),
    .ready_count_o  (ready_count_o),
    .ctl_i          (ctl),
    .sts_o          (sts)
  );

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while another is in progress");

  a_chosen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> chosen_id_o == '0)
    else $error("chosen id set on a failed command");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL) |-> ready_count_o == LW'(MAX_TASKS))
    else $error("table full reported below capacity");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ready_count_o <= LW'(MAX_TASKS))
    else $error("ready count beyond capacity");

endmodule

`default_nettype wire

FILE: sim/aging_priority_task_picker_core_tb.sv
// Self-checking testbench for aging_priority_task_picker_core with a ready-list predictor.
`timescale 1ns / 1ps

module aging_priority_task_picker_core_tb;
  import aptp_pkg::*;

  localparam int CountW        = $clog2(MaxTasksDef + 1);
  localparam int WatchdogLimit = 3000;
  localparam int HoldOffCycles = 400;
  localparam int PhaseItems    = 215;

  typedef struct {
    status_e           status;
    logic [IdW-1:0]    chosen;
    logic [CountW-1:0] count;
  } outcome_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [LimitW-1:0]       cfg_wdata = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [1:0]              cmd = CMD_ADD;
  logic [IdW-1:0]          task_id = '0;
  logic signed [PrioW-1:0] prio_req = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [1:0]              status;
  logic [IdW-1:0]          chosen_id;
  logic [CountW-1:0]       ready_count;

  logic [IdW-1:0]           rl_id   [MaxTasksDef];
  logic signed [PrioW-1:0]  rl_prio [MaxTasksDef];
  logic [AgeW-1:0]          rl_age  [MaxTasksDef];
  int                       rl_len = 0;
  logic signed [LimitW-1:0] rl_limit = LimitReset;

  outcome_t predicted_outcomes[$];

  int errors = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int gap_max = 0;
  int hold_len = 0;
  int hold_cnt = 0;
  logic [15:0] rx_pattern = 16'hFFFF;
  logic [3:0]  rx_phase = '0;
  int n_requests = 0;
  int n_granted = 0;
  int n_none = 0;
  int n_full = 0;
  int n_unknown = 0;

  always #5 clk = ~clk;

  aging_priority_task_picker_core uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .cmd_i          (cmd),
    .task_id_i      (task_id),
    .priority_req_i (prio_req),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .status_o       (status),
    .chosen_id_o    (chosen_id),
    .ready_count_o  (ready_count)
  );

  task automatic drop_entry(input int pos);
    for (int i = pos; i + 1 < rl_len; i++) begin
      rl_id[i]   = rl_id[i + 1];
      rl_prio[i] = rl_prio[i + 1];
      rl_age[i]  = rl_age[i + 1];
    end
    rl_len--;
  endtask

  task automatic ready_list_step(input cmd_e op, input logic [IdW-1:0] id,
                                 input logic signed [PrioW-1:0] prio, output outcome_t res);
    int pos;
    int best;
    int win;
    int eff;
    logic [IdW-1:0] wid;
    logic signed [PrioW-1:0] wpr;
    res.status = ST_OK;
    res.chosen = '0;
    pos = -1;
    case (op)
      CMD_ADD: begin
        if (rl_len >= MaxTasksDef) begin
          res.status = ST_FULL;
        end else begin
          rl_id[rl_len]   = id;
          rl_prio[rl_len] = prio;
          rl_age[rl_len]  = '0;
          rl_len++;
        end
      end
      CMD_REMOVE, CMD_SET_PRIO: begin
        for (int i = rl_len - 1; i >= 0; i--) begin
          if (rl_id[i] == id) pos = i;
        end
        if (pos < 0) res.status = ST_NOT_FOUND;
        else if (op == CMD_REMOVE) drop_entry(pos);
        else rl_prio[pos] = prio;
      end
      default: begin
        best = int'(rl_limit);
        win = -1;
        for (int i = 0; i < rl_len; i++) begin
          eff = int'(rl_prio[i]) - int'(rl_age[i]);
          if (eff < best) begin
            best = eff;
            win = i;
          end
          if (rl_age[i] != AgeMax) rl_age[i] = rl_age[i] + 1'b1;
        end
        if (win < 0) begin
          res.status = ST_NONE;
        end else begin
          wid = rl_id[win];
          wpr = rl_prio[win];
          drop_entry(win);
          rl_id[rl_len]   = wid;
          rl_prio[rl_len] = wpr;
          rl_age[rl_len]  = '0;
          rl_len++;
          res.chosen = wid;
        end
      end
    endcase
    res.count = CountW'(rl_len);
    n_requests++;
    case (res.status)
      ST_FULL:      n_full++;
      ST_NOT_FOUND: n_unknown++;
      ST_NONE:      n_none++;
      default:      if (op == CMD_PICK) n_granted++;
    endcase
  endtask

  always @(posedge clk) begin : check_results
    outcome_t want;
    outcome_t got;
    if (rst_n && out_valid && out_ready) begin
      if (predicted_outcomes.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: status %0d id %0d count %0d", $time, status,
                 chosen_id, ready_count);
      end else begin
        want = predicted_outcomes.pop_front();
        if (status !== want.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, want.status, status);
        end
        if (chosen_id !== want.chosen) begin
          errors++;
          $display("%0t: chosen_id expected %0d actual %0d", $time, want.chosen, chosen_id);
        end
        if (ready_count !== want.count) begin
          errors++;
          $display("%0t: ready_count expected %0d actual %0d", $time, want.count,
                   ready_count);
        end
      end
    end
    if (rst_n && in_valid && in_ready) begin
      ready_list_step(cmd_e'(cmd), task_id, prio_req, got);
      predicted_outcomes.push_back(got);
    end
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchdogLimit) begin
      $display("%0t: no progress for %0d cycles", $time, idle_cycles);
      $display("status: fail");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_len > 0) begin
      hold_cnt = hold_len;
      hold_len = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rx_pattern[rx_phase];
      rx_phase <= rx_phase + 1'b1;
    end
  end

  task automatic random_request(output cmd_e op, output logic [IdW-1:0] id,
                                output logic signed [PrioW-1:0] prio);
    int r;
    int add_w;
    add_w = (rl_len < 4) ? 55 : (rl_len >= 14) ? 15 : 30;
    r = $urandom_range(0, 99);
    if (r < add_w) op = CMD_ADD;
    else if (r < add_w + 15) op = CMD_REMOVE;
    else if (r < add_w + 30) op = CMD_SET_PRIO;
    else op = CMD_PICK;
    if (op != CMD_ADD && rl_len > 0 && $urandom_range(0, 3) != 0)
      id = rl_id[$urandom_range(0, rl_len - 1)];
    else if ($urandom_range(0, 3) == 0) id = IdW'($urandom_range(0, 255));
    else id = IdW'($urandom_range(0, 23));
    if ($urandom_range(0, 7) == 0) prio = PrioW'($urandom_range(0, 63));
    else prio = PrioW'($urandom_range(0, 40) - 20);
  endtask

  task automatic send_request(input cmd_e op, input logic [IdW-1:0] id,
                              input logic signed [PrioW-1:0] prio, input bit draw);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (gap_max > 0) gap = $urandom_range(1, gap_max);
    end
    burst_left--;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    if (draw) random_request(op, id, prio);
    in_valid <= 1'b1;
    cmd      <= op;
    task_id  <= id;
    prio_req <= prio;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic pause_sender;
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (predicted_outcomes.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_select_limit(input logic signed [LimitW-1:0] value);
    pause_sender();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    rl_limit = value;
  endtask

  task automatic set_traffic(input int gaps, input bit busy);
    gap_max = gaps;
    rx_pattern = busy ? (16'($urandom) | 16'h0101) : 16'hFFFF;
  endtask

  task automatic test_directed;
    set_traffic(3, 1);
    send_request(CMD_PICK, 0, 0, 0);
    send_request(CMD_REMOVE, 5, 0, 0);
    send_request(CMD_SET_PRIO, 5, 3, 0);
    send_request(CMD_ADD, 0, -32, 0);
    send_request(CMD_ADD, 255, 31, 0);
    send_request(CMD_ADD, 7, -20, 0);
    send_request(CMD_ADD, 7, 20, 0);
    send_request(CMD_ADD, 128, 0, 0);
    send_request(CMD_ADD, 1, -1, 0);
    send_request(CMD_ADD, 2, 5, 0);
    send_request(CMD_ADD, 64, 10, 0);
    send_request(CMD_ADD, 3, -5, 0);
    send_request(CMD_ADD, 170, 15, 0);
    send_request(CMD_ADD, 85, -10, 0);
    send_request(CMD_ADD, 4, 12, 0);
    send_request(CMD_ADD, 200, -3, 0);
    send_request(CMD_ADD, 9, 1, 0);
    send_request(CMD_ADD, 10, 2, 0);
    send_request(CMD_ADD, 11, 7, 0);
    send_request(CMD_ADD, 12, 0, 0);
    send_request(CMD_SET_PRIO, 7, -32, 0);
    send_request(CMD_REMOVE, 7, 0, 0);
    send_request(CMD_PICK, 0, 0, 0);
    send_request(CMD_PICK, 0, 0, 0);
  endtask

  task automatic test_limit_extremes;
    int limits[5];
    limits = '{-64, 63, -1, 0, 20};
    foreach (limits[k]) begin
      write_select_limit(LimitW'(limits[k]));
      set_traffic(k * 2, k[0]);
      repeat (40) send_request(CMD_PICK, 0, 0, 1);
    end
  endtask

  task automatic test_backpressure;
    pause_sender();
    set_traffic(0, 0);
    hold_len = HoldOffCycles;
    repeat (30) send_request(CMD_PICK, 0, 0, 1);
    pause_sender();
  endtask

  task automatic test_random_traffic;
    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 3) write_select_limit(-64);
      else if (phase == 5) write_select_limit(63);
      else write_select_limit(LimitW'($urandom_range(0, 127)));
      set_traffic(phase[0] ? 0 : 8, !phase[0]);
      repeat (PhaseItems) send_request(CMD_PICK, 0, 0, 1);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_limit_extremes();
    test_backpressure();
    test_random_traffic();
    pause_sender();
    repeat (50) @(posedge clk);
    $display("Run covered %0d requests: %0d picks granted, %0d picks with no winner,",
             n_requests, n_granted, n_none);
    $display("%0d adds to a full table, %0d unknown ids, select_limit from -64 to 63.",
             n_full, n_unknown);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

FILE: filelist.f
sv/aptp_pkg.sv
sv/aptp_ctrl.sv
sv/aptp_dpath.sv
sv/aging_priority_task_picker_core.sv
sim/aging_priority_task_picker_core_tb.sv
